>>> rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared constants and types for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CAP_W      = 5;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 2;
	localparam int ADDR_W     = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

	typedef logic signed [DATA_WIDTH-1:0] word_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [CAP_W-1:0]             cap_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_REAR  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_REAR   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	localparam logic [ADDR_W-1:0] REG_CAPACITY = 3'd0;

	typedef struct packed {
		logic wr_en;
		idx_t wr_slot;
		idx_t rd_slot;
	} store_ctl_t;

endpackage

>>> rtl/cdq_if.sv
// ----------------------------------------------------------------------------
// cdq_if
// Valid/ready channels for deque commands and results.
// ----------------------------------------------------------------------------
interface cdq_in_if;
	logic                     valid;
	logic                     ready;
	logic [cdq_pkg::CMD_W-1:0] cmd;
	cdq_pkg::word_t           push_value;

	modport source (output valid, output cmd, output push_value, input ready);
	modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface cdq_out_if;
	logic                      valid;
	logic                      ready;
	logic [cdq_pkg::STAT_W-1:0] status;
	cdq_pkg::word_t            popped_value;

	modport source (output valid, output status, output popped_value, input ready);
	modport sink   (input valid, input status, input popped_value, output ready);
endinterface

>>> rtl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue on a ring of word cells with an APB capacity register.
// Result: registered in the cycle after the command word is taken.
// Throughput: one command per cycle while the result side is ready; the index
// update and the cell row read/write for a command complete in the cycle it is accepted.
// Reset: queue empty, both indices zero, capacity 16; cell contents undefined.
// ----------------------------------------------------------------------------
module circular_deque (
	input  logic                          clk,
	input  logic                          arst_n,
	cdq_in_if.sink                        req,
	cdq_out_if.source                     rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cdq_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	cdq_pkg::cap_t       cap_q;
	logic                cfg_wr;
	cdq_pkg::store_ctl_t ctl;
	cdq_pkg::word_t      wdata;
	cdq_pkg::word_t      rd_chain [cdq_pkg::DEPTH+1];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[cdq_pkg::ADDR_W-1:2] == cdq_pkg::REG_CAPACITY[cdq_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cdq_pkg::CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[cdq_pkg::CAP_W-1:0];
		end
	end

	assign prdata = (paddr[cdq_pkg::ADDR_W-1:2] == cdq_pkg::REG_CAPACITY[cdq_pkg::ADDR_W-1:2])
		? {{(32-cdq_pkg::CAP_W){1'b0}}, cap_q} : '0;

	cdq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.cfg_wr  (cfg_wr),
		.cap_cfg (cap_q),
		.ctl     (ctl),
		.wdata   (wdata),
		.rd_data (rd_chain[cdq_pkg::DEPTH])
	);

	assign rd_chain[0] = '0;

	for (genvar i = 0; i < cdq_pkg::DEPTH; i++) begin : g_cell
		cdq_cell u_cell (
			.clk     (clk),
			.cell_id (cdq_pkg::IDX_W'(i)),
			.ctl     (ctl),
			.wdata   (wdata),
			.rd_in   (rd_chain[i]),
			.rd_out  (rd_chain[i+1])
		);
	end

endmodule

>>> rtl/cdq_cell.sv
// ----------------------------------------------------------------------------
// cdq_cell
// One ring slot: holds a word and passes the read word along the row.
// ----------------------------------------------------------------------------
module cdq_cell (
	input  logic                 clk,
	input  cdq_pkg::idx_t        cell_id,
	input  cdq_pkg::store_ctl_t  ctl,
	input  cdq_pkg::word_t       wdata,
	input  cdq_pkg::word_t       rd_in,
	output cdq_pkg::word_t       rd_out
);

	cdq_pkg::word_t word_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en && ctl.wr_slot == cell_id) begin
			word_q <= wdata;
		end
	end

	assign rd_out = (ctl.rd_slot == cell_id) ? word_q : rd_in;

endmodule

>>> rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Front/rear indices, full/empty decisions and the result register.
// ----------------------------------------------------------------------------
module cdq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	cdq_in_if.sink              req,
	cdq_out_if.source           rsp,
	input  logic                cfg_wr,
	input  cdq_pkg::cap_t       cap_cfg,
	output cdq_pkg::store_ctl_t ctl,
	output cdq_pkg::word_t      wdata,
	input  cdq_pkg::word_t      rd_data
);

	cdq_pkg::idx_t  front_q, rear_q;
	logic           empty_q;
	logic           out_valid_q;
	logic [cdq_pkg::STAT_W-1:0] status_q;
	cdq_pkg::word_t popped_q;

	cdq_pkg::cap_t  cap;
	cdq_pkg::cmd_t  cmd;
	logic           fire, is_push, full;
	cdq_pkg::idx_t  front_dn, front_up, rear_up, rear_dn;

	function automatic cdq_pkg::idx_t step_up(cdq_pkg::idx_t idx, cdq_pkg::cap_t c);
		cdq_pkg::cap_t nxt;
		nxt = {1'b0, idx} + cdq_pkg::CAP_W'(1);
		return (nxt >= c) ? '0 : nxt[cdq_pkg::IDX_W-1:0];
	endfunction

	function automatic cdq_pkg::idx_t step_down(cdq_pkg::idx_t idx, cdq_pkg::cap_t c);
		cdq_pkg::cap_t top;
		top = c - cdq_pkg::CAP_W'(1);
		return (idx == '0) ? top[cdq_pkg::IDX_W-1:0] : idx - cdq_pkg::IDX_W'(1);
	endfunction

	always_comb begin
		if (cap_cfg == '0) begin
			cap = cdq_pkg::CAP_W'(1);
		end else if (cap_cfg > cdq_pkg::CAP_W'(cdq_pkg::DEPTH)) begin
			cap = cdq_pkg::CAP_W'(cdq_pkg::DEPTH);
		end else begin
			cap = cap_cfg;
		end
	end

	assign cmd       = cdq_pkg::cmd_t'(req.cmd);
	assign req.ready = !out_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign is_push   = (cmd == cdq_pkg::CMD_PUSH_FRONT) || (cmd == cdq_pkg::CMD_PUSH_REAR);

	assign front_dn = step_down(front_q, cap);
	assign front_up = step_up(front_q, cap);
	assign rear_up  = step_up(rear_q, cap);
	assign rear_dn  = step_down(rear_q, cap);
	assign full     = !empty_q && (rear_up == front_q);

	always_comb begin
		ctl.wr_en   = fire && is_push && !full && !cfg_wr;
		ctl.wr_slot = empty_q ? '0 :
			(cmd == cdq_pkg::CMD_PUSH_FRONT) ? front_dn : rear_up;
		ctl.rd_slot = (cmd == cdq_pkg::CMD_POP_FRONT) ? front_q : rear_q;
	end

	assign wdata = req.push_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
		end else if (cfg_wr) begin
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
		end else if (fire) begin
			if (is_push) begin
				if (!full) begin
					if (empty_q) begin
						front_q <= '0;
						rear_q  <= '0;
						empty_q <= 1'b0;
					end else if (cmd == cdq_pkg::CMD_PUSH_FRONT) begin
						front_q <= front_dn;
					end else begin
						rear_q <= rear_up;
					end
				end
			end else if (!empty_q) begin
				if (front_q == rear_q) begin
					front_q <= '0;
					rear_q  <= '0;
					empty_q <= 1'b1;
				end else if (cmd == cdq_pkg::CMD_POP_FRONT) begin
					front_q <= front_up;
				end else begin
					rear_q <= rear_dn;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (is_push) begin
				status_q <= full ? cdq_pkg::ST_FULL : cdq_pkg::ST_DONE;
				popped_q <= '0;
			end else if (empty_q) begin
				status_q <= cdq_pkg::ST_EMPTY;
				popped_q <= '0;
			end else begin
				status_q <= cdq_pkg::ST_DONE;
				popped_q <= rd_data;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.popped_value = popped_q;

endmodule

>>> bench/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker
// Watches the command, result and APB ports of the circular deque, keeps its
// own ring, indices and capacity register, predicts the result of every
// command word taken and compares each result word in order.
// ----------------------------------------------------------------------------
module cdq_checker import cdq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	cdq_in_if                 req,
	cdq_out_if                rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic [31:0]       prdata,
	input  logic              pready,
	output int                errors,
	output int                pending,
	output int                checked,
	output int                refused_full,
	output int                refused_empty
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t st;
		word_t   val;
	} outcome_t;

	cap_t     cap_reg;
	idx_t     head;
	idx_t     tail;
	logic     vacant;
	word_t    cells [DEPTH];
	outcome_t due_q [$];
	outcome_t due;
	int       bad;

	task automatic note_failure(input string msg);
		bad++;
		if (bad <= 10) begin
			$display("%0t ns  %s", $time, msg);
		end
	endtask

	function automatic outcome_t apply_command(input cmd_t c, input word_t v);
		outcome_t o;
		int       n;
		o.st  = ST_DONE;
		o.val = '0;
		n = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
		case (c)
			CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
				if (!vacant && ((int'(tail) + 1) % n) == int'(head)) begin
					o.st = ST_FULL;
				end else if (vacant) begin
					head     = '0;
					tail     = '0;
					vacant   = 1'b0;
					cells[0] = v;
				end else if (c == CMD_PUSH_FRONT) begin
					head        = idx_t'((int'(head) + n - 1) % n);
					cells[head] = v;
				end else begin
					tail        = idx_t'((int'(tail) + 1) % n);
					cells[tail] = v;
				end
			end
			CMD_POP_FRONT, CMD_POP_REAR: begin
				if (vacant) begin
					o.st = ST_EMPTY;
				end else begin
					o.val = (c == CMD_POP_FRONT) ? cells[head] : cells[tail];
					if (head == tail) begin
						head   = '0;
						tail   = '0;
						vacant = 1'b1;
					end else if (c == CMD_POP_FRONT) begin
						head = idx_t'((int'(head) + 1) % n);
					end else begin
						tail = idx_t'((int'(tail) + n - 1) % n);
					end
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_reg = CAP_RESET;
			head    = '0;
			tail    = '0;
			vacant  = 1'b1;
			bad     = 0;
			due_q.delete();
			errors        <= 0;
			pending       <= 0;
			checked       <= 0;
			refused_full  <= 0;
			refused_empty <= 0;
		end else begin
			// writes with paddr bit 2 set are ignored by the block; addresses 0 to 3 all reach the capacity register
			if (psel && penable && pready &&
				paddr[ADDR_W-1:2] == REG_CAPACITY[ADDR_W-1:2]) begin
				if (pwrite) begin
					cap_reg = cap_t'(pwdata);
					head    = '0;
					tail    = '0;
					vacant  = 1'b1;
				end else if (prdata !== 32'(cap_reg)) begin
					note_failure($sformatf("capacity read: expected %0d, got %0d",
						cap_reg, prdata));
				end
			end
			if (rsp.valid && rsp.ready) begin
				if (due_q.size() == 0) begin
					note_failure($sformatf("result word with nothing outstanding: status %0d value %0d",
						rsp.status, $signed(rsp.popped_value)));
				end else begin
					due = due_q.pop_front();
					checked <= checked + 1;
					if (rsp.status !== due.st || rsp.popped_value !== due.val) begin
						note_failure($sformatf(
							"result %0d: expected status %0d value %0d, got status %0d value %0d",
							checked, due.st, $signed(due.val), rsp.status,
							$signed(rsp.popped_value)));
					end
				end
			end
			if (req.valid && req.ready) begin
				due = apply_command(cmd_t'(req.cmd), req.push_value);
				due_q.push_back(due);
				if (due.st == ST_FULL) begin
					refused_full <= refused_full + 1;
				end
				if (due.st == ST_EMPTY) begin
					refused_empty <= refused_empty + 1;
				end
			end
			pending <= due_q.size();
			errors  <= bad;
		end
	end

endmodule

>>> bench/tb_circular_deque.sv
// ----------------------------------------------------------------------------
// tb_circular_deque
// Drives command words into the circular deque with random gaps and result
// stalls, rewrites the capacity register between phases (including zero and
// out-of-range values) and leaves all prediction and comparison to the
// checker, whose failure count decides the verdict.
// ----------------------------------------------------------------------------
module tb_circular_deque;
	import cdq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ADDR_W-1:0] REG_SPARE = 3'd4;
	localparam int TARGET      = 920;
	localparam int HOLD_CYCLES = 80;
	localparam int QUIET_LIMIT = 5000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int errors;
	int pending;
	int checked;
	int refused_full;
	int refused_empty;
	int sent;
	int settings;
	int quiet;
	bit calm;
	bit hold_req;

	cdq_in_if  req_if ();
	cdq_out_if rsp_if ();

	circular_deque uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	cdq_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_if),
		.rsp           (rsp_if),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.errors        (errors),
		.pending       (pending),
		.checked       (checked),
		.refused_full  (refused_full),
		.refused_empty (refused_empty)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic word_t pick_value();
		case ($urandom_range(0, 19))
			0:       return {1'b1, 31'd0};
			1:       return {1'b0, {31{1'b1}}};
			2:       return '1;
			3:       return '0;
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic cmd_t pick_cmd(input int push_pct);
		bit rear;
		rear = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < push_pct) return rear ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
		return rear ? CMD_POP_REAR : CMD_POP_FRONT;
	endfunction

	task automatic issue(input cmd_t c, input word_t v);
		int g;
		g = pick_gap();
		if (g > 0) begin
			req_if.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.cmd        <= c;
		req_if.push_value <= v;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		sent++;
	endtask

	task automatic settle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apb_access(input logic [ADDR_W-1:0] a, input bit wr, input logic [31:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic new_capacity(input logic [31:0] d);
		settle();
		apb_access(REG_CAPACITY, 1'b1, d);
		apb_access(REG_CAPACITY, 1'b0, '0);
		settings++;
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		rsp_if.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					rsp_if.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			rsp_if.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("tb_circular_deque: done, errors");
			$finish;
		end
	end

	initial begin
		int          phase;
		int          len;
		int          push_pct;
		logic [31:0] cap_word;
		arst_n            <= 1'b0;
		req_if.valid      <= 1'b0;
		req_if.cmd        <= CMD_PUSH_FRONT;
		req_if.push_value <= '0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		calm     = 1'b0;
		hold_req = 1'b0;
		sent     = 0;
		settings = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset capacity: empty pops, extreme words at both ends
		issue(CMD_POP_FRONT, '0);
		issue(CMD_POP_REAR, '1);
		issue(CMD_PUSH_FRONT, {1'b1, 31'd0});
		issue(CMD_PUSH_REAR, {1'b0, {31{1'b1}}});
		issue(CMD_PUSH_FRONT, '1);
		issue(CMD_PUSH_REAR, '0);
		// unmapped register: queue must survive
		settle();
		apb_access(REG_SPARE, 1'b1, 32'd1);
		issue(CMD_POP_FRONT, '0);
		issue(CMD_POP_REAR, '0);
		issue(CMD_POP_REAR, '0);
		issue(CMD_POP_FRONT, '0);
		issue(CMD_POP_REAR, '0);

		// two slots: wrap both ways, refuse when full
		new_capacity(32'd2);
		issue(CMD_PUSH_REAR, 32'sd1);
		issue(CMD_PUSH_FRONT, 32'sd2);
		issue(CMD_PUSH_REAR, 32'sd3);
		issue(CMD_PUSH_FRONT, 32'sd4);
		issue(CMD_POP_REAR, '0);
		issue(CMD_POP_FRONT, '0);
		issue(CMD_PUSH_REAR, 32'sd5);

		// zero capacity behaves as one slot; the write empties the queue
		new_capacity(32'd0);
		issue(CMD_POP_FRONT, '0);
		issue(CMD_PUSH_FRONT, -32'sd6);
		issue(CMD_PUSH_REAR, 32'sd7);
		issue(CMD_POP_REAR, '0);
		new_capacity(32'hFFFF_FFFF);

		phase = 0;
		while (sent < TARGET) begin
			case (phase % 6)
				0:       cap_word = 32'd1;
				1:       cap_word = 32'd16;
				2:       cap_word = $urandom_range(2, 15);
				3:       cap_word = 32'd0;
				4:       cap_word = $urandom;
				default: cap_word = $urandom_range(17, 31);
			endcase
			new_capacity(cap_word);
			calm     = ($urandom_range(0, 3) == 0);
			len      = $urandom_range(60, 140);
			push_pct = 50;
			for (int i = 0; i < len; i++) begin
				if (i % 20 == 0) begin
					case ($urandom_range(0, 2))
						0:       push_pct = 85;
						1:       push_pct = 15;
						default: push_pct = 50;
					endcase
				end
				issue(pick_cmd(push_pct), pick_value());
			end
			if (phase == 2) begin
				calm     = 1'b1;
				hold_req = 1'b1;
				for (int i = 0; i < 40; i++) begin
					issue(pick_cmd(70), pick_value());
				end
			end
			phase++;
		end

		settle();
		repeat (10) @(posedge clk);
		$display("%0d command words over %0d capacity settings, %0d results compared",
			sent, settings, checked);
		$display("refusals seen: %0d on a full queue, %0d on an empty one",
			refused_full, refused_empty);
		if (errors == 0) begin
			$display("tb_circular_deque: done, clean");
		end else begin
			$display("tb_circular_deque: done, errors");
		end
		$finish;
	end

endmodule
